// File: rtl/core/lapbtr_pkg.sv
// lapbtr_pkg: codes, frame constants and types shared by the LAPB timer recovery block.
// No dependencies.
package lapbtr_pkg;

    localparam int QUEUE_LEN_BITS_DEF = 16;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RX_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OLD_PROTOCOL   = 2'd3;

    localparam logic [7:0] RETRY_LIMIT_RST    = 8'd10;
    localparam int         RX_WINDOW_RST      = 2048;
    localparam int         POLL_THRESHOLD_RST = 128;

    localparam logic [1:0] CMD_T1   = 2'd0;
    localparam logic [1:0] CMD_T2   = 2'd1;
    localparam logic [1:0] CMD_POLL = 2'd2;

    localparam logic [2:0] ST_DISC  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DPEND = 3'd2;
    localparam logic [2:0] ST_CONN  = 3'd3;
    localparam logic [2:0] ST_RECOV = 3'd4;
    localparam logic [2:0] ST_FRMR  = 3'd5;

    localparam logic [1:0] SK_NONE   = 2'd0;
    localparam logic [1:0] SK_CTL    = 2'd1;
    localparam logic [1:0] SK_IFRAME = 2'd2;
    localparam logic [1:0] SK_FRMR   = 2'd3;

    localparam logic [7:0] CTL_SABM = 8'h2F;
    localparam logic [7:0] CTL_DISC = 8'h43;
    localparam logic [7:0] CTL_DM   = 8'h0F;
    localparam logic [7:0] CTL_RR   = 8'h01;
    localparam logic [7:0] CTL_RNR  = 8'h05;
    localparam logic [7:0] CTL_PF   = 8'h10;
    localparam logic [7:0] CTL_I    = 8'h00;
    localparam logic [2:0] SEQ_MASK = 3'h7;

    typedef struct packed {
        logic [2:0] state;
        logic [7:0] retry;
        logic [1:0] kind;
        logic       cmd;
        logic [7:0] ctl;
        logic       flush;
        logic       t1;
        logic       t3;
        logic       resp;
        logic       rel;
    } result_t;

endpackage

// File: rtl/core/lapb_timer_recovery.sv
// lapb_timer_recovery: top level with input beat register, decision and result register.
// Depends on lapbtr_pkg and lapbtr_decide.
// An accepted beat goes into the input register, then its result into the result register.
// Throughput: one beat per cycle while out_stall is low; the two registers form a two-deep pipe.
// Reset: pipe valids clear, registers load retry_limit 10, rx_window 2048,
// poll_threshold 128, old_protocol 0.
module lapb_timer_recovery
    import lapbtr_pkg::*;
#(
    parameter int QUEUE_LEN_BITS = QUEUE_LEN_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [QUEUE_LEN_BITS-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [2:0]                link_state,
    input  logic [7:0]                retry_count,
    input  logic                      tx_pending,
    input  logic [QUEUE_LEN_BITS-1:0] oldest_frame_len,
    input  logic [QUEUE_LEN_BITS-1:0] rx_queued_bytes,
    input  logic                      remote_busy,
    input  logic [2:0]                send_seq,
    input  logic [2:0]                unacked_count,
    input  logic [2:0]                recv_seq,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                next_state,
    output logic [7:0]                next_retry_count,
    output logic [1:0]                send_kind,
    output logic                      is_command,
    output logic [7:0]                control_byte,
    output logic                      flush_tx_queue,
    output logic                      restart_t1,
    output logic                      stop_t3,
    output logic                      clear_response,
    output logic                      release_link
);

    logic [7:0]                retry_limit_reg;
    logic [QUEUE_LEN_BITS-1:0] rx_window_reg;
    logic [QUEUE_LEN_BITS-1:0] poll_threshold_reg;
    logic                      old_protocol_reg;

    logic                      s1_valid_reg;
    logic [1:0]                command_reg;
    logic [2:0]                link_state_reg;
    logic [7:0]                retry_count_reg;
    logic                      tx_pending_reg;
    logic [QUEUE_LEN_BITS-1:0] oldest_frame_len_reg;
    logic [QUEUE_LEN_BITS-1:0] rx_queued_bytes_reg;
    logic                      remote_busy_reg;
    logic [2:0]                send_seq_reg;
    logic [2:0]                unacked_count_reg;
    logic [2:0]                recv_seq_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   out_reg;
    result_t                   res;

    logic                      out_ready;
    logic                      s1_take;
    logic                      s1_valid_next;
    logic                      in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg    <= RETRY_LIMIT_RST;
            rx_window_reg      <= QUEUE_LEN_BITS'(RX_WINDOW_RST);
            poll_threshold_reg <= QUEUE_LEN_BITS'(POLL_THRESHOLD_RST);
            old_protocol_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RETRY_LIMIT:    retry_limit_reg    <= cfg_data[7:0];
                CFG_RX_WINDOW:      rx_window_reg      <= cfg_data;
                CFG_POLL_THRESHOLD: poll_threshold_reg <= cfg_data;
                CFG_OLD_PROTOCOL:   old_protocol_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_ready      = !out_valid_reg || !out_stall;
    assign s1_take        = s1_valid_reg && out_ready;
    assign in_stall       = s1_valid_reg && !out_ready;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !out_ready);
    assign out_valid_next = s1_take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            command_reg          <= command;
            link_state_reg       <= link_state;
            retry_count_reg      <= retry_count;
            tx_pending_reg       <= tx_pending;
            oldest_frame_len_reg <= oldest_frame_len;
            rx_queued_bytes_reg  <= rx_queued_bytes;
            remote_busy_reg      <= remote_busy;
            send_seq_reg         <= send_seq;
            unacked_count_reg    <= unacked_count;
            recv_seq_reg         <= recv_seq;
        end
        if (s1_take)
        begin
            out_reg <= res;
        end
    end

    lapbtr_decide #(
        .QUEUE_LEN_BITS (QUEUE_LEN_BITS)
    ) u_decide (
        .command          (command_reg),
        .link_state       (link_state_reg),
        .retry_count      (retry_count_reg),
        .tx_pending       (tx_pending_reg),
        .oldest_frame_len (oldest_frame_len_reg),
        .rx_queued_bytes  (rx_queued_bytes_reg),
        .remote_busy      (remote_busy_reg),
        .send_seq         (send_seq_reg),
        .unacked_count    (unacked_count_reg),
        .recv_seq         (recv_seq_reg),
        .retry_limit      (retry_limit_reg),
        .rx_window        (rx_window_reg),
        .poll_threshold   (poll_threshold_reg),
        .old_protocol     (old_protocol_reg),
        .res              (res)
    );

    assign out_valid        = out_valid_reg;
    assign next_state       = out_reg.state;
    assign next_retry_count = out_reg.retry;
    assign send_kind        = out_reg.kind;
    assign is_command       = out_reg.cmd;
    assign control_byte     = out_reg.ctl;
    assign flush_tx_queue   = out_reg.flush;
    assign restart_t1       = out_reg.t1;
    assign stop_t3          = out_reg.t3;
    assign clear_response   = out_reg.resp;
    assign release_link     = out_reg.rel;

    // a beat held in the input register must not vanish while the result side is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_ready |=> s1_valid_reg)
        else $error("input register beat lost under stall");

    a_release_disc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rel |-> out_reg.state == ST_DISC)
        else $error("release without disconnected state");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == SK_NONE |-> out_reg.ctl == 8'd0 && !out_reg.cmd)
        else $error("control byte set with nothing sent");

    a_flush_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.flush |-> out_reg.rel)
        else $error("flush without link release");

    a_t1_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.t1 |-> out_reg.kind != SK_NONE)
        else $error("T1 restart without a frame");

endmodule

// File: rtl/core/lapbtr_decide.sv
// lapbtr_decide: combinational action decision for one timer event.
// Depends on lapbtr_pkg.
module lapbtr_decide
    import lapbtr_pkg::*;
#(
    parameter int QUEUE_LEN_BITS = QUEUE_LEN_BITS_DEF
)
(
    input  logic [1:0]                command,
    input  logic [2:0]                link_state,
    input  logic [7:0]                retry_count,
    input  logic                      tx_pending,
    input  logic [QUEUE_LEN_BITS-1:0] oldest_frame_len,
    input  logic [QUEUE_LEN_BITS-1:0] rx_queued_bytes,
    input  logic                      remote_busy,
    input  logic [2:0]                send_seq,
    input  logic [2:0]                unacked_count,
    input  logic [2:0]                recv_seq,
    input  logic [7:0]                retry_limit,
    input  logic [QUEUE_LEN_BITS-1:0] rx_window,
    input  logic [QUEUE_LEN_BITS-1:0] poll_threshold,
    input  logic                      old_protocol,
    output result_t                   res
);

    logic [7:0] rc_eff;
    logic [7:0] rc_inc;
    logic       give_up;
    logic [2:0] ns;
    logic       use_iframe;
    logic [1:0] poll_kind;
    logic [7:0] poll_ctl;

    assign rc_eff     = (link_state == ST_CONN) ? 8'd0 : retry_count;
    assign give_up    = (retry_limit != 8'd0) && (rc_eff == retry_limit);
    assign rc_inc     = (rc_eff == 8'hFF) ? 8'hFF : rc_eff + 8'd1;
    assign ns         = (send_seq - unacked_count) & SEQ_MASK;
    assign use_iframe = tx_pending && (oldest_frame_len < poll_threshold)
                        && (old_protocol || !remote_busy);
    assign poll_kind  = use_iframe ? SK_IFRAME : SK_CTL;

    always_comb
    begin
        if (use_iframe)
        begin
            poll_ctl = CTL_PF | CTL_I | {recv_seq, 5'b0} | {4'b0, ns, 1'b0};
        end
        else if (rx_queued_bytes >= rx_window)
        begin
            poll_ctl = CTL_RNR | CTL_PF;
        end
        else
        begin
            poll_ctl = CTL_RR | CTL_PF;
        end
    end

    always_comb
    begin
        res       = '0;
        res.state = link_state;
        res.retry = retry_count;
        case (command)
            CMD_T1:
            begin
                case (link_state)
                    ST_DISC:
                    begin
                        res.rel = 1'b1;
                    end
                    ST_SETUP, ST_DPEND:
                    begin
                        if (give_up)
                        begin
                            res.flush = (link_state == ST_SETUP);
                            res.state = ST_DISC;
                            res.rel   = 1'b1;
                        end
                        else
                        begin
                            res.retry = rc_inc;
                            res.kind  = SK_CTL;
                            res.cmd   = 1'b1;
                            res.ctl   = (link_state == ST_SETUP) ? (CTL_SABM | CTL_PF)
                                                                 : (CTL_DISC | CTL_PF);
                            res.t1    = 1'b1;
                        end
                    end
                    ST_CONN, ST_RECOV, ST_FRMR:
                    begin
                        if (give_up)
                        begin
                            res.kind  = SK_CTL;
                            res.ctl   = CTL_DM | CTL_PF;
                            res.flush = 1'b1;
                            res.state = ST_DISC;
                            res.rel   = 1'b1;
                        end
                        else if (link_state == ST_FRMR)
                        begin
                            res.kind  = SK_FRMR;
                            res.t1    = 1'b1;
                            res.retry = rc_inc;
                        end
                        else
                        begin
                            res.kind  = poll_kind;
                            res.ctl   = poll_ctl;
                            res.cmd   = 1'b1;
                            res.resp  = 1'b1;
                            res.t3    = 1'b1;
                            res.t1    = 1'b1;
                            res.retry = rc_inc;
                            res.state = ST_RECOV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_T2:
            begin
                if (link_state == ST_CONN || link_state == ST_RECOV)
                begin
                    res.kind = SK_CTL;
                    res.ctl  = (rx_queued_bytes > rx_window) ? CTL_RNR : CTL_RR;
                    res.resp = 1'b1;
                end
            end
            CMD_POLL:
            begin
                if (!old_protocol && link_state == ST_CONN)
                begin
                    res.kind  = poll_kind;
                    res.ctl   = poll_ctl;
                    res.cmd   = 1'b1;
                    res.resp  = 1'b1;
                    res.t3    = 1'b1;
                    res.t1    = 1'b1;
                    res.retry = 8'd0;
                    res.state = ST_RECOV;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
